// ===== sv/ecc_pkg.sv =====
// ----------------------------------------------------------------------------
// ecc_pkg
// Shared types, constants and the segment decoder of the elevator car
// controller.
// ----------------------------------------------------------------------------
package ecc_pkg;

  localparam int FLOORS       = 4;
  localparam int FLOOR_HEIGHT = 10;
  localparam int FLOOR_IDX_W  = (FLOORS > 1) ? $clog2(FLOORS) : 1;

  // reciprocal for an exact 8-bit divide by the floor height
  localparam int unsigned DIV_RECIP = (65536 + FLOOR_HEIGHT - 1) / FLOOR_HEIGHT;

  localparam logic [7:0] TARGET_RESET    = 8'd30;
  localparam logic [4:0] OPEN_STEPS_RST  = 5'd20;
  localparam logic [7:0] HOLD_TICKS_RST  = 8'd10;
  localparam logic [1:0] BLINK_TICKS_RST = 2'd3;

  localparam logic [1:0] DRV_OFF  = 2'd0;
  localparam logic [1:0] DRV_UP   = 2'd1;
  localparam logic [1:0] DRV_DOWN = 2'd2;
  localparam logic [1:0] DRV_OPEN = 2'd1;
  localparam logic [1:0] DRV_SHUT = 2'd2;

  localparam logic [1:0] REG_OPEN_STEPS  = 2'd0;
  localparam logic [1:0] REG_HOLD_TICKS  = 2'd1;
  localparam logic [1:0] REG_BLINK_TICKS = 2'd2;

  typedef enum logic [2:0] {
    PH_OPEN   = 3'd0,
    PH_HOLD   = 3'd1,
    PH_CLOSE  = 3'd2,
    PH_CHOOSE = 3'd3,
    PH_MOVE   = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    CS_IDLE,
    CS_SCAN,
    CS_WRITE
  } ctl_state_t;

  typedef struct packed {
    logic step;
    logic scan_step;
    logic load_out;
  } ctl_cmd_t;

  typedef struct packed {
    logic pick_req;
    logic scan_last;
    logic out_full;
  } dp_status_t;

  function automatic logic [6:0] seg_pattern(input logic [1:0] floor_idx);
    logic [6:0] pat;
    unique case (floor_idx)
      2'd0: pat = 7'h3F;
      2'd1: pat = 7'h06;
      2'd2: pat = 7'h5B;
      default: pat = 7'h4F;
    endcase
    return pat;
  endfunction

endpackage

// ===== sv/ecc_ctrl.sv =====
// ----------------------------------------------------------------------------
// ecc_ctrl
// Sequencer: takes a tick, runs the call scan when the choosing phase asks
// for it, then hands the result to the output register.
// ----------------------------------------------------------------------------
module ecc_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                out_ready,
  input  ecc_pkg::dp_status_t status,
  output ecc_pkg::ctl_cmd_t   cmd
);

  ecc_pkg::ctl_state_t state, state_next;
  logic                out_free;

  assign out_free = !status.out_full || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ecc_pkg::CS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ecc_pkg::CS_IDLE: begin
        if (in_valid) begin
          state_next = status.pick_req ? ecc_pkg::CS_SCAN : ecc_pkg::CS_WRITE;
        end
      end
      ecc_pkg::CS_SCAN: begin
        if (status.scan_last) state_next = ecc_pkg::CS_WRITE;
      end
      ecc_pkg::CS_WRITE: begin
        if (out_free) state_next = ecc_pkg::CS_IDLE;
      end
      default: state_next = ecc_pkg::CS_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = 1'b0;
    cmd.step      = 1'b0;
    cmd.scan_step = 1'b0;
    cmd.load_out  = 1'b0;
    unique case (state)
      ecc_pkg::CS_IDLE: begin
        in_ready = 1'b1;
        cmd.step = in_valid;
      end
      ecc_pkg::CS_SCAN: begin
        cmd.scan_step = 1'b1;
      end
      ecc_pkg::CS_WRITE: begin
        cmd.load_out = out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

// ===== sv/ecc_datapath.sv =====
// ----------------------------------------------------------------------------
// ecc_datapath
// Car state, door and display logic, nearest call scan and the output
// register.
// ----------------------------------------------------------------------------
module ecc_datapath (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic [1:0]          cfg_index,
  input  logic [7:0]          cfg_data,
  input  logic                beam_blocked,
  input  logic                alarm_button,
  input  logic                overload,
  input  logic [3:0]          cabin_calls,
  input  logic [3:0]          hall_calls,
  input  ecc_pkg::ctl_cmd_t   cmd,
  output ecc_pkg::dp_status_t status,
  input  logic                out_ready,
  output logic                out_valid,
  output logic [1:0]          lift_drive,
  output logic [1:0]          door_drive,
  output logic [6:0]          segments,
  output logic [1:0]          floor_number,
  output logic [2:0]          phase_now
);

  localparam int FW = ecc_pkg::FLOOR_IDX_W;

  // configuration
  logic [4:0] door_open_steps;
  logic [7:0] door_hold_ticks;
  logic [1:0] blink_ticks;

  // car state
  ecc_pkg::phase_t       phase, phase_next;
  logic [7:0]            car_height, car_height_next;
  logic [1:0]            shown_floor, shown_floor_next;
  logic [4:0]            door_position, door_position_next;
  logic [7:0]            hold_count, hold_count_next;
  logic                  alarm_latch, alarm_latch_next;
  logic                  overload_latch, overload_latch_next;
  logic [7:0]            target_height, target_height_next;
  logic                  target_valid, target_valid_next;
  logic [ecc_pkg::FLOORS-1:0] call_pending, call_pending_next;
  logic [1:0]            lift_mode, lift_mode_next;
  logic [1:0]            door_mode, door_mode_next;
  logic                  blink_enable, blink_enable_next;
  logic                  display_lit, display_lit_next;
  logic [1:0]            blink_count, blink_count_next;
  logic [6:0]            seg_hold, seg_hold_next;

  // scan
  logic [FW-1:0] scan_idx;
  logic [7:0]    best_dist;
  logic          found;
  logic [7:0]    scan_h;
  logic [7:0]    scan_dist;

  // output register
  logic       out_full;
  logic [1:0] out_lift;
  logic [1:0] out_door;
  logic [6:0] out_seg;
  logic [1:0] out_floor;
  logic [2:0] out_phase;

  // divide by floor height
  logic [24:0] div_prod;
  logic [7:0]  car_floor;
  logic [7:0]  floor_base;
  logic [7:0]  car_rem;

  logic        any_alarm;
  logic        any_over;
  logic [3:0]  calls;

  assign div_prod   = {17'd0, car_height} * 25'(ecc_pkg::DIV_RECIP);
  assign car_floor  = div_prod[23:16];
  assign floor_base = 8'(car_floor * 8'(ecc_pkg::FLOOR_HEIGHT));
  assign car_rem    = car_height - floor_base;

  assign any_alarm = alarm_latch | alarm_button;
  assign any_over  = overload_latch | overload;
  assign calls     = (cabin_calls != 4'd0) ? cabin_calls : hall_calls;

  assign scan_h    = 8'(8'(scan_idx) * 8'(ecc_pkg::FLOOR_HEIGHT));
  assign scan_dist = (car_height < scan_h) ? scan_h - car_height : car_height - scan_h;

  assign status.pick_req  = (phase == ecc_pkg::PH_CHOOSE) && !any_alarm && !any_over &&
                            !target_valid;
  assign status.scan_last = (scan_idx == FW'(ecc_pkg::FLOORS - 1));
  assign status.out_full  = out_full;

  // one tick of the car
  always_comb begin
    phase_next          = phase;
    car_height_next     = car_height;
    shown_floor_next    = shown_floor;
    door_position_next  = door_position;
    hold_count_next     = hold_count;
    alarm_latch_next    = alarm_latch;
    overload_latch_next = overload_latch;
    target_height_next  = target_height;
    target_valid_next   = target_valid;
    call_pending_next   = call_pending;
    lift_mode_next      = lift_mode;
    door_mode_next      = door_mode;
    blink_enable_next   = blink_enable;
    display_lit_next    = display_lit;
    blink_count_next    = blink_count;

    // display refresh comes first
    if (!blink_enable) begin
      display_lit_next = 1'b1;
      blink_count_next = 2'd0;
    end else if (blink_count == blink_ticks) begin
      blink_count_next = 2'd0;
      display_lit_next = !display_lit;
    end else begin
      blink_count_next = blink_count + 2'd1;
    end
    seg_hold_next = display_lit_next ? ecc_pkg::seg_pattern(shown_floor) : 7'd0;

    case (phase)
      ecc_pkg::PH_OPEN: begin
        blink_enable_next = 1'b1;
        if (door_position < door_open_steps) begin
          door_position_next = door_position + 5'd1;
          door_mode_next     = ecc_pkg::DRV_OPEN;
        end else begin
          door_mode_next  = ecc_pkg::DRV_OFF;
          hold_count_next = door_hold_ticks;
          phase_next      = ecc_pkg::PH_HOLD;
        end
      end
      ecc_pkg::PH_HOLD: begin
        if (hold_count != 8'd0) hold_count_next = hold_count - 8'd1;
        else phase_next = ecc_pkg::PH_CLOSE;
      end
      ecc_pkg::PH_CLOSE: begin
        if (beam_blocked) begin
          phase_next = ecc_pkg::PH_OPEN;
        end else if (door_position != 5'd0) begin
          door_position_next = door_position - 5'd1;
          door_mode_next     = ecc_pkg::DRV_SHUT;
        end else begin
          door_mode_next = ecc_pkg::DRV_OFF;
          phase_next     = ecc_pkg::PH_CHOOSE;
        end
      end
      ecc_pkg::PH_CHOOSE: begin
        alarm_latch_next    = any_alarm;
        overload_latch_next = any_over;
        blink_enable_next   = 1'b0;
        if (any_alarm || any_over) begin
          target_height_next = car_height;
          target_valid_next  = 1'b1;
          phase_next         = ecc_pkg::PH_MOVE;
        end else if (!target_valid) begin
          // pick of the nearest call follows in the scan
          call_pending_next = call_pending | calls[ecc_pkg::FLOORS-1:0];
        end else begin
          phase_next = ecc_pkg::PH_MOVE;
        end
      end
      ecc_pkg::PH_MOVE: begin
        alarm_latch_next    = 1'b0;
        overload_latch_next = 1'b0;
        if (car_rem == 8'd0) shown_floor_next = car_floor[1:0];
        // emergency stop at the next floor in the travel direction
        if (any_alarm || any_over) begin
          target_height_next = (car_height < target_height) ?
                               floor_base + 8'(ecc_pkg::FLOOR_HEIGHT) : floor_base;
        end
        if (car_height < target_height_next) begin
          car_height_next = car_height + 8'd1;
          lift_mode_next  = ecc_pkg::DRV_UP;
        end else if (car_height > target_height_next) begin
          car_height_next = car_height - 8'd1;
          lift_mode_next  = ecc_pkg::DRV_DOWN;
        end else begin
          lift_mode_next = ecc_pkg::DRV_OFF;
          if (car_floor < 8'(ecc_pkg::FLOORS)) begin
            call_pending_next[car_floor[FW-1:0]] = 1'b0;
          end
          target_valid_next = 1'b0;
          phase_next        = ecc_pkg::PH_OPEN;
        end
      end
      default: begin
        phase_next = phase;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      door_open_steps <= ecc_pkg::OPEN_STEPS_RST;
      door_hold_ticks <= ecc_pkg::HOLD_TICKS_RST;
      blink_ticks     <= ecc_pkg::BLINK_TICKS_RST;
      phase           <= ecc_pkg::PH_CHOOSE;
      car_height      <= 8'd0;
      shown_floor     <= 2'd0;
      door_position   <= 5'd0;
      hold_count      <= 8'd0;
      alarm_latch     <= 1'b0;
      overload_latch  <= 1'b0;
      target_height   <= ecc_pkg::TARGET_RESET;
      target_valid    <= 1'b0;
      call_pending    <= '0;
      lift_mode       <= ecc_pkg::DRV_OFF;
      door_mode       <= ecc_pkg::DRV_OFF;
      blink_enable    <= 1'b0;
      display_lit     <= 1'b1;
      blink_count     <= 2'd0;
      scan_idx        <= '0;
      found           <= 1'b0;
      out_full        <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          ecc_pkg::REG_OPEN_STEPS:  door_open_steps <= cfg_data[4:0];
          ecc_pkg::REG_HOLD_TICKS:  door_hold_ticks <= cfg_data;
          ecc_pkg::REG_BLINK_TICKS: blink_ticks     <= cfg_data[1:0];
          default: ;
        endcase
      end
      if (cmd.step) begin
        phase          <= phase_next;
        car_height     <= car_height_next;
        shown_floor    <= shown_floor_next;
        door_position  <= door_position_next;
        hold_count     <= hold_count_next;
        alarm_latch    <= alarm_latch_next;
        overload_latch <= overload_latch_next;
        target_height  <= target_height_next;
        target_valid   <= target_valid_next;
        call_pending   <= call_pending_next;
        lift_mode      <= lift_mode_next;
        door_mode      <= door_mode_next;
        blink_enable   <= blink_enable_next;
        display_lit    <= display_lit_next;
        blink_count    <= blink_count_next;
        scan_idx       <= '0;
        found          <= 1'b0;
      end else if (cmd.scan_step) begin
        // ascending scan with strict compare: ties keep the lower floor
        if (call_pending[scan_idx] && (!found || scan_dist < best_dist)) begin
          target_height <= scan_h;
          target_valid  <= 1'b1;
          found         <= 1'b1;
        end
        scan_idx <= scan_idx + FW'(1);
      end
      if (cmd.load_out) begin
        out_full <= 1'b1;
      end else if (out_ready) begin
        out_full <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.step) begin
      seg_hold <= seg_hold_next;
    end
    if (cmd.scan_step && call_pending[scan_idx] && (!found || scan_dist < best_dist)) begin
      best_dist <= scan_dist;
    end
    if (cmd.load_out) begin
      out_lift  <= lift_mode;
      out_door  <= door_mode;
      out_seg   <= seg_hold;
      out_floor <= shown_floor;
      out_phase <= phase;
    end
  end

  assign out_valid    = out_full;
  assign lift_drive   = out_lift;
  assign door_drive   = out_door;
  assign segments     = out_seg;
  assign floor_number = out_floor;
  assign phase_now    = out_phase;

endmodule

// ===== sv/elevator_car_controller.sv =====
// ----------------------------------------------------------------------------
// elevator_car_controller
// Four-landing elevator car controller advanced by one timer tick per item.
// ----------------------------------------------------------------------------
// Each accepted tick gives exactly one result with the motor drives, the
// display pattern, the shown floor and the phase after that tick. A tick is
// accepted, then loaded into the output register; a tick in the choosing
// phase that looks for a new destination runs the nearest call scan in
// between, which visits one floor per cycle. A new tick
// is taken while the previous result still waits in the output register; the
// block only stalls once that register is full and not being taken.
// Configuration writes are applied at once and are meant for idle periods.
module elevator_car_controller (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       beam_blocked,
  input  logic       alarm_button,
  input  logic       overload,
  input  logic [3:0] cabin_calls,
  input  logic [3:0] hall_calls,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] lift_drive,
  output logic [1:0] door_drive,
  output logic [6:0] segments,
  output logic [1:0] floor_number,
  output logic [2:0] phase_now
);

  ecc_pkg::ctl_cmd_t   cmd;
  ecc_pkg::dp_status_t status;

  ecc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  ecc_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .beam_blocked (beam_blocked),
    .alarm_button (alarm_button),
    .overload     (overload),
    .cabin_calls  (cabin_calls),
    .hall_calls   (hall_calls),
    .cmd          (cmd),
    .status       (status),
    .out_ready    (out_ready),
    .out_valid    (out_valid),
    .lift_drive   (lift_drive),
    .door_drive   (door_drive),
    .segments     (segments),
    .floor_number (floor_number),
    .phase_now    (phase_now)
  );

endmodule

// ===== sv/ecc_checker.sv =====
// ----------------------------------------------------------------------------
// ecc_checker
// Port-level checks of the elevator car controller, bound to the top level.
// ----------------------------------------------------------------------------
module ecc_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] lift_drive,
  input logic [1:0] door_drive,
  input logic [6:0] segments,
  input logic [2:0] phase_now
);

  // a held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(lift_drive) &&
    $stable(door_drive) && $stable(segments) && $stable(phase_now))
    else $error("result changed while stalled");

  // one tick at a time
  a_one_tick: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second tick taken back to back");

  // drive codes and phases stay in range
  a_codes: assert property (@(posedge clk) disable iff (rst)
    out_valid |->
    (lift_drive == ecc_pkg::DRV_OFF || lift_drive == ecc_pkg::DRV_UP ||
     lift_drive == ecc_pkg::DRV_DOWN) &&
    (door_drive == ecc_pkg::DRV_OFF || door_drive == ecc_pkg::DRV_OPEN ||
     door_drive == ecc_pkg::DRV_SHUT) &&
    (phase_now == ecc_pkg::PH_OPEN || phase_now == ecc_pkg::PH_HOLD ||
     phase_now == ecc_pkg::PH_CLOSE || phase_now == ecc_pkg::PH_CHOOSE ||
     phase_now == ecc_pkg::PH_MOVE))
    else $error("bad drive code or phase");

  // hoist is off while the door phases run
  a_hoist_off: assert property (@(posedge clk) disable iff (rst)
    out_valid && (phase_now == ecc_pkg::PH_OPEN || phase_now == ecc_pkg::PH_HOLD ||
                  phase_now == ecc_pkg::PH_CLOSE) |->
    lift_drive == ecc_pkg::DRV_OFF)
    else $error("hoist running with door active");

endmodule

bind elevator_car_controller ecc_checker u_ecc_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .lift_drive (lift_drive),
  .door_drive (door_drive),
  .segments   (segments),
  .phase_now  (phase_now)
);

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the elevator car controller. Ticks go in over a
// valid/ready channel with random gaps. A cycle-free model of the car, door,
// display and call logic predicts the status after every tick, and each status
// that comes out is compared field by field, in order, with the prediction.
// Directed ticks cover the beam reopening the door, cabin calls winning over
// hall calls, alarm and overload, and zero door steps. Random traffic follows
// under several register settings, the extremes among them.
// ----------------------------------------------------------------------------
module testbench;

  localparam int WAIT_MAX      = 18;
  localparam int STALL_LIMIT   = 1000;
  localparam int SETTLE_CYCLES = 12;

  // seven-segment patterns of floors 0..3, floor 0 in the low bits
  localparam logic [27:0] DIGIT_PATTERNS = {7'h4F, 7'h5B, 7'h06, 7'h3F};

  typedef struct packed {
    logic       beam;
    logic       alarm;
    logic       over;
    logic [3:0] cabin;
    logic [3:0] hall;
  } tick_t;

  typedef struct packed {
    logic [1:0]       lift;
    logic [1:0]       door;
    logic [6:0]       seg;
    logic [1:0]       floor;
    ecc_pkg::phase_t  ph;
  } car_status_t;

  logic       clk;
  logic       rst;
  logic       cfg_write;
  logic [1:0] cfg_index;
  logic [7:0] cfg_data;
  logic       in_valid;
  logic       in_ready;
  logic       beam_blocked;
  logic       alarm_button;
  logic       overload;
  logic [3:0] cabin_calls;
  logic [3:0] hall_calls;
  logic       out_valid;
  logic       out_ready;
  logic [1:0] lift_drive;
  logic [1:0] door_drive;
  logic [6:0] segments;
  logic [1:0] floor_number;
  logic [2:0] phase_now;

  elevator_car_controller DUT (.*);

  // car model: registers
  logic [4:0] open_steps;
  logic [7:0] hold_ticks;
  logic [1:0] blink_period;

  // car model: state
  ecc_pkg::phase_t car_phase;
  logic [7:0] car_height;
  logic [7:0] dest_height;
  logic       dest_set;
  logic [1:0] display_floor;
  logic [4:0] door_pos;
  logic [7:0] hold_left;
  logic       alarm_held;
  logic       overload_held;
  logic [3:0] floor_called;
  logic [1:0] hoist_mode;
  logic [1:0] door_act;
  logic       blink_on;
  logic       lit;
  logic [1:0] blink_cnt;

  car_status_t expected_status[$];
  car_status_t arrived_want;
  int          mismatch_count;
  int          idle_cycles;
  bit          sender_calm;
  bit          receiver_calm;

  always #1 clk = ~clk;

  function automatic void reset_car_model();
    open_steps    = ecc_pkg::OPEN_STEPS_RST;
    hold_ticks    = ecc_pkg::HOLD_TICKS_RST;
    blink_period  = ecc_pkg::BLINK_TICKS_RST;
    car_phase     = ecc_pkg::PH_CHOOSE;
    car_height    = 8'd0;
    dest_height   = ecc_pkg::TARGET_RESET;
    dest_set      = 1'b0;
    display_floor = 2'd0;
    door_pos      = 5'd0;
    hold_left     = 8'd0;
    alarm_held    = 1'b0;
    overload_held = 1'b0;
    floor_called  = 4'b0000;
    hoist_mode    = ecc_pkg::DRV_OFF;
    door_act      = ecc_pkg::DRV_OFF;
    blink_on      = 1'b0;
    lit           = 1'b1;
    blink_cnt     = 2'd0;
  endfunction

  // advances the car model by one tick and returns the status it shows
  function automatic car_status_t next_car_status(tick_t t);
    car_status_t r;
    logic [6:0]  pattern;
    logic [3:0]  calls;
    int          n, h, d, best_dist, best_h, stop, f;
    bit          found;

    if (!blink_on) begin
      lit = 1'b1;
      blink_cnt = 2'd0;
    end else if (blink_cnt == blink_period) begin
      blink_cnt = 2'd0;
      lit = ~lit;
    end else begin
      blink_cnt = blink_cnt + 2'd1;
    end
    pattern = lit ? DIGIT_PATTERNS[display_floor * 7 +: 7] : 7'd0;

    case (car_phase)
      ecc_pkg::PH_OPEN: begin
        blink_on = 1'b1;
        if (door_pos < open_steps) begin
          door_pos = door_pos + 5'd1;
          door_act = ecc_pkg::DRV_OPEN;
        end else begin
          door_act = ecc_pkg::DRV_OFF;
          hold_left = hold_ticks;
          car_phase = ecc_pkg::PH_HOLD;
        end
      end
      ecc_pkg::PH_HOLD: begin
        if (hold_left > 0) hold_left = hold_left - 8'd1;
        else car_phase = ecc_pkg::PH_CLOSE;
      end
      ecc_pkg::PH_CLOSE: begin
        if (t.beam) begin
          car_phase = ecc_pkg::PH_OPEN;
        end else if (door_pos > 0) begin
          door_pos = door_pos - 5'd1;
          door_act = ecc_pkg::DRV_SHUT;
        end else begin
          door_act = ecc_pkg::DRV_OFF;
          car_phase = ecc_pkg::PH_CHOOSE;
        end
      end
      ecc_pkg::PH_CHOOSE: begin
        if (t.alarm) alarm_held = 1'b1;
        if (t.over) overload_held = 1'b1;
        blink_on = 1'b0;
        if (alarm_held || overload_held) begin
          dest_height = car_height;
          dest_set = 1'b1;
          car_phase = ecc_pkg::PH_MOVE;
        end else if (!dest_set) begin
          calls = (t.cabin != 4'd0) ? t.cabin : t.hall;
          for (n = 0; n < ecc_pkg::FLOORS && n < 4; n++)
            if (calls[n]) floor_called[n] = 1'b1;
          // nearest pending floor, lower floor kept on a tie
          best_dist = 1000;
          best_h = 0;
          found = 1'b0;
          for (n = 0; n < ecc_pkg::FLOORS && n < 4; n++) begin
            if (floor_called[n]) begin
              h = n * ecc_pkg::FLOOR_HEIGHT;
              d = (car_height < h) ? h - car_height : car_height - h;
              if (d < best_dist) begin
                best_dist = d;
                best_h = h;
                found = 1'b1;
              end
            end
          end
          if (found) begin
            dest_height = best_h[7:0];
            dest_set = 1'b1;
          end
        end else begin
          car_phase = ecc_pkg::PH_MOVE;
        end
      end
      ecc_pkg::PH_MOVE: begin
        if (t.alarm) alarm_held = 1'b1;
        if (t.over) overload_held = 1'b1;
        if (car_height % ecc_pkg::FLOOR_HEIGHT == 0) begin
          f = car_height / ecc_pkg::FLOOR_HEIGHT;
          display_floor = f[1:0];
        end
        if (overload_held) begin
          overload_held = 1'b0;
          alarm_held = 1'b1;
        end
        // emergency: stop at the next landing in the direction of travel
        if (alarm_held) begin
          stop = (car_height / ecc_pkg::FLOOR_HEIGHT) * ecc_pkg::FLOOR_HEIGHT;
          if (car_height < dest_height) stop = stop + ecc_pkg::FLOOR_HEIGHT;
          dest_height = stop[7:0];
          alarm_held = 1'b0;
        end
        if (car_height < dest_height) begin
          car_height = car_height + 8'd1;
          hoist_mode = ecc_pkg::DRV_UP;
        end else if (car_height > dest_height) begin
          car_height = car_height - 8'd1;
          hoist_mode = ecc_pkg::DRV_DOWN;
        end else begin
          f = car_height / ecc_pkg::FLOOR_HEIGHT;
          hoist_mode = ecc_pkg::DRV_OFF;
          if (f < ecc_pkg::FLOORS && f < 4) floor_called[f] = 1'b0;
          dest_set = 1'b0;
          car_phase = ecc_pkg::PH_OPEN;
        end
      end
      default: ;
    endcase

    r.lift  = hoist_mode;
    r.door  = door_act;
    r.seg   = pattern;
    r.floor = display_floor;
    r.ph    = car_phase;
    return r;
  endfunction

  function automatic tick_t make_tick(logic beam, logic alarm, logic over,
                                      logic [3:0] cabin, logic [3:0] hall);
    tick_t t;
    t.beam  = beam;
    t.alarm = alarm;
    t.over  = over;
    t.cabin = cabin;
    t.hall  = hall;
    return t;
  endfunction

  function automatic tick_t random_tick(int beam_odds);
    tick_t t;
    t.beam  = ($urandom_range(0, beam_odds - 1) == 0);
    t.alarm = ($urandom_range(0, 59) == 0);
    t.over  = ($urandom_range(0, 59) == 0);
    t.cabin = ($urandom_range(0, 2) == 0) ? 4'($urandom_range(0, 15)) : 4'd0;
    t.hall  = ($urandom_range(0, 1) == 0) ? 4'($urandom_range(0, 15)) : 4'd0;
    return t;
  endfunction

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("mismatch on %s: expected %0d, got %0d", name, want, got);
    end
  endfunction

  // one tick transfer; valid stays high on return so back-to-back ticks need
  // no extra edge
  task automatic send_tick(tick_t t);
    int gap;
    gap = sender_calm ? 0 : $urandom_range(0, WAIT_MAX);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    beam_blocked <= t.beam;
    alarm_button <= t.alarm;
    overload     <= t.over;
    cabin_calls  <= t.cabin;
    hall_calls   <= t.hall;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_status.push_back(next_car_status(t));
    @(negedge clk);
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(negedge clk);
    while (expected_status.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [7:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    case (idx)
      ecc_pkg::REG_OPEN_STEPS:  open_steps = value[4:0];
      ecc_pkg::REG_HOLD_TICKS:  hold_ticks = value;
      ecc_pkg::REG_BLINK_TICKS: blink_period = value[1:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic apply_settings(logic [4:0] steps, logic [7:0] hold, logic [1:0] blink);
    write_reg(ecc_pkg::REG_OPEN_STEPS, {3'd0, steps});
    write_reg(ecc_pkg::REG_HOLD_TICKS, hold);
    write_reg(ecc_pkg::REG_BLINK_TICKS, {6'd0, blink});
    cfg_write <= 1'b0;
    @(negedge clk);
  endtask

  task automatic tick_until(ecc_pkg::phase_t goal, tick_t filler);
    while (car_phase != goal) send_tick(filler);
  endtask

  task automatic run_traffic(int items, logic [4:0] steps, logic [7:0] hold,
                             logic [1:0] blink, int beam_odds);
    int k;
    wait_for_results();
    apply_settings(steps, hold, blink);
    for (k = 0; k < items; k++) begin
      if (k % 25 == 0) begin
        sender_calm   = ($urandom_range(0, 3) == 0);
        receiver_calm = ($urandom_range(0, 3) == 0);
      end
      // halfway through, let every status drain before going on
      if (k == items / 2) wait_for_results();
      send_tick(random_tick(beam_odds));
    end
    sender_calm   = 1'b0;
    receiver_calm = 1'b0;
  endtask

  task automatic test_reset_state();
    send_tick(make_tick(1'b1, 1'b0, 1'b0, 4'd0, 4'd0));
    send_tick(make_tick(1'b0, 1'b0, 1'b0, 4'd0, 4'd0));
  endtask

  task automatic test_beam_reopens_door();
    wait_for_results();
    apply_settings(5'd1, 8'd0, 2'd0);
    // cabin button present, so the hall buttons are ignored
    send_tick(make_tick(1'b0, 1'b0, 1'b0, 4'b0001, 4'b1110));
    tick_until(ecc_pkg::PH_CLOSE, make_tick(1'b1, 1'b0, 1'b0, 4'd0, 4'd0));
    send_tick(make_tick(1'b1, 1'b0, 1'b0, 4'd0, 4'd0));
    tick_until(ecc_pkg::PH_CHOOSE, make_tick(1'b0, 1'b0, 1'b0, 4'd0, 4'd0));
    send_tick(make_tick(1'b0, 1'b0, 1'b0, 4'd0, 4'b0010));
  endtask

  task automatic test_zero_door_steps();
    wait_for_results();
    apply_settings(5'd0, 8'd0, 2'd1);
    send_tick(make_tick(1'b0, 1'b1, 1'b0, 4'b1111, 4'b1111));
    tick_until(ecc_pkg::PH_CHOOSE, make_tick(1'b0, 1'b0, 1'b0, 4'd0, 4'd0));
    send_tick(make_tick(1'b0, 1'b0, 1'b1, 4'd0, 4'd0));
    tick_until(ecc_pkg::PH_CHOOSE, make_tick(1'b0, 1'b0, 1'b0, 4'd0, 4'd0));
  endtask

  task automatic test_slow_door();
    run_traffic(80, 5'd31, 8'd0, 2'd0, 30);
  endtask

  task automatic test_long_hold();
    run_traffic(60, 5'd1, 8'd255, 2'd3, 8);
  endtask

  task automatic test_default_timing();
    run_traffic(90, ecc_pkg::OPEN_STEPS_RST, ecc_pkg::HOLD_TICKS_RST,
                ecc_pkg::BLINK_TICKS_RST, 40);
  endtask

  task automatic test_mixed_settings();
    int b;
    run_traffic(60, 5'd3, 8'd2, 2'd2, 10);
    for (b = 0; b < 5; b++)
      run_traffic(60, 5'($urandom_range(1, 6)), 8'($urandom_range(0, 4)),
                  2'($urandom_range(0, 3)), $urandom_range(6, 20));
  endtask

  // result side: random stall before each status transfer
  initial begin : result_sink
    int stall;
    out_ready = 1'b0;
    do @(negedge clk); while (rst);
    forever begin
      stall = receiver_calm ? 0 : $urandom_range(0, WAIT_MAX);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (expected_status.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("status transfer with nothing expected, phase_now %0d", phase_now);
        end else begin
          arrived_want = expected_status.pop_front();
          check_field("lift_drive", arrived_want.lift, lift_drive);
          check_field("door_drive", arrived_want.door, door_drive);
          check_field("segments", arrived_want.seg, segments);
          check_field("floor_number", arrived_want.floor, floor_number);
          check_field("phase_now", arrived_want.ph, phase_now);
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("no transfer for %0d cycles", STALL_LIMIT);
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    clk            = 1'b0;
    rst            = 1'b1;
    cfg_write      = 1'b0;
    cfg_index      = ecc_pkg::REG_OPEN_STEPS;
    cfg_data       = 8'd0;
    in_valid       = 1'b0;
    beam_blocked   = 1'b0;
    alarm_button   = 1'b0;
    overload       = 1'b0;
    cabin_calls    = 4'd0;
    hall_calls     = 4'd0;
    sender_calm    = 1'b0;
    receiver_calm  = 1'b0;
    mismatch_count = 0;
    idle_cycles    = 0;
    reset_car_model();
    repeat (3) @(negedge clk);
    rst <= 1'b0;

    test_reset_state();
    test_beam_reopens_door();
    test_zero_door_steps();
    test_slow_door();
    test_long_hold();
    test_default_timing();
    test_mixed_settings();

    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_status.size() == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== sim.f =====
sv/ecc_pkg.sv
sv/ecc_ctrl.sv
sv/ecc_datapath.sv
sv/elevator_car_controller.sv
sv/ecc_checker.sv
bench/testbench.sv
